// ===== hdl/psh_pkg.sv =====
// Shared types and constants for the polynomial string hash unit.
package psh_pkg;

   localparam int CHAR_W     = 8;
   localparam int POS_W      = 16;
   localparam int HASH_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int OMIT_CNT_W = 4;
   localparam int DIV_CNT_W  = $clog2(HASH_W);

   localparam logic [CSR_IDX_W-1:0] CSR_START_OFFSET  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_LENGTH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_CHAR     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MULTIPLIER    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OMITTED_SET   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OMITTED_COUNT = 3'd6;

   localparam logic [HASH_W-1:0] MULTIPLIER_RESET = 32'd31;
   localparam logic [HASH_W-1:0] TABLE_SIZE_RESET = 32'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic take_byte;
      logic div_step;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic out_free;
   } status_type;

endpackage

// ===== hdl/polynomial_string_hash_unit.sv =====
// A non-final byte is folded in as it is accepted; req_tready stays high within a string.
// Throughput: one byte per cycle within a string, set by the single 32x32 multiply-add.
// The last byte starts a 32-step bit-serial remainder; the bucket is published once the
// steps are done and the output register is free, and intake stays blocked until then.
// Reset (synchronous, active high): config registers return to defaults, string state clears,
// no result pending.
module polynomial_string_hash_unit import psh_pkg::*; #(
   parameter int MAX_OMITTED = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] char_byte
   input  logic                  req_tlast,   // is_last
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [HASH_W-1:0]     rsp_tdata,   // [31:0] bucket
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   psh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   psh_datapath #(
      .MAX_OMITTED (MAX_OMITTED)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .char_byte  (req_tdata[CHAR_W-1:0]),
      .is_last    (req_tlast),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== hdl/psh_ctrl.sv =====
// Controller state machine: byte intake, modulo iterations, result hand-off.
module psh_ctrl import psh_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take_byte = 1'b1;
               if (req_tlast) begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            // wait for the output register to drain
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/psh_datapath.sv =====
// Datapath: config registers, hash accumulator, remainder unit, output register.
module psh_datapath import psh_pkg::*; #(
   parameter int MAX_OMITTED = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic [CHAR_W-1:0]     char_byte,
   input  logic                  is_last,
   input  cmd_type               cmd,
   output status_type            status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [HASH_W-1:0]     rsp_tdata
);

   // configuration
   logic [POS_W-1:0]      start_offset_ff;
   logic [POS_W-1:0]      hash_length_ff;
   logic [CHAR_W-1:0]     base_char_ff;
   logic [HASH_W-1:0]     multiplier_ff;
   logic [HASH_W-1:0]     table_size_ff;
   logic [CSR_DATA_W-1:0] omitted_set_ff;
   logic [OMIT_CNT_W-1:0] omitted_count_ff;

   // per-string state
   logic [HASH_W-1:0] hash_acc_ff, hash_acc_in;
   logic [POS_W-1:0]  position_ff, position_in;
   logic [POS_W-1:0]  remaining_ff, remaining_in;
   logic              stopped_ff, stopped_in;

   // remainder unit
   logic [HASH_W-1:0]    div_rem_ff, div_dvd_ff, div_den_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [HASH_W:0]      div_trial;
   logic [HASH_W:0]      div_diff;

   logic                  rsp_valid_ff;
   logic [HASH_W-1:0]     rsp_data_ff;

   logic [OMIT_CNT_W-1:0] omit_n;
   logic                  omit_hit;
   logic [POS_W-1:0]      rem_cur;
   logic                  past_offset;
   logic [HASH_W-1:0]     product;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_offset_ff  <= '0;
         hash_length_ff   <= '0;
         base_char_ff     <= '0;
         multiplier_ff    <= MULTIPLIER_RESET;
         table_size_ff    <= TABLE_SIZE_RESET;
         omitted_set_ff   <= '0;
         omitted_count_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_START_OFFSET:  start_offset_ff  <= csr_data[POS_W-1:0];
            CSR_HASH_LENGTH:   hash_length_ff   <= csr_data[POS_W-1:0];
            CSR_BASE_CHAR:     base_char_ff     <= csr_data[CHAR_W-1:0];
            CSR_MULTIPLIER:    multiplier_ff    <= csr_data[HASH_W-1:0];
            CSR_TABLE_SIZE:    table_size_ff    <= csr_data[HASH_W-1:0];
            CSR_OMITTED_SET:   omitted_set_ff   <= csr_data;
            CSR_OMITTED_COUNT: omitted_count_ff <= csr_data[OMIT_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      omit_n = (omitted_count_ff > OMIT_CNT_W'(MAX_OMITTED)) ?
               OMIT_CNT_W'(MAX_OMITTED) : omitted_count_ff;
      omit_hit = 1'b0;
      for (int i = 0; i < MAX_OMITTED; i++) begin
         if ((OMIT_CNT_W'(i) < omit_n) && (omitted_set_ff[CHAR_W*i +: CHAR_W] == char_byte)) begin
            omit_hit = 1'b1;
         end
      end
   end

   assign product     = multiplier_ff * hash_acc_ff;
   // budget reloads on the first byte of each string
   assign rem_cur     = (position_ff == '0) ? hash_length_ff : remaining_ff;
   assign past_offset = (position_ff >= start_offset_ff) || (position_ff == '1);

   always_comb begin
      hash_acc_in  = hash_acc_ff;
      remaining_in = rem_cur;
      stopped_in   = stopped_ff;
      position_in  = (position_ff == '1) ? position_ff : position_ff + 1'b1;
      if (!stopped_ff) begin
         if (char_byte == '0) begin
            stopped_in = 1'b1;
         end else if (past_offset && (rem_cur != '0) && !omit_hit) begin
            remaining_in = rem_cur - 1'b1;
            hash_acc_in  = ({{(HASH_W-CHAR_W){1'b0}}, char_byte}
                            - {{(HASH_W-CHAR_W){1'b0}}, base_char_ff}) + product;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_acc_ff  <= '0;
         position_ff  <= '0;
         remaining_ff <= '0;
         stopped_ff   <= 1'b0;
      end else if (cmd.take_byte) begin
         if (is_last) begin
            hash_acc_ff  <= '0;
            position_ff  <= '0;
            remaining_ff <= hash_length_ff;
            stopped_ff   <= 1'b0;
         end else begin
            hash_acc_ff  <= hash_acc_in;
            position_ff  <= position_in;
            remaining_ff <= remaining_in;
            stopped_ff   <= stopped_in;
         end
      end
   end

   // restoring remainder, one dividend bit per step; a zero divisor passes the hash through
   assign div_trial = {div_rem_ff, div_dvd_ff[HASH_W-1]};
   assign div_diff  = div_trial - {1'b0, div_den_ff};

   always_ff @(posedge clock) begin
      if (cmd.take_byte && is_last) begin
         div_rem_ff <= '0;
         div_dvd_ff <= hash_acc_in;
         div_den_ff <= table_size_ff;
      end else if (cmd.div_step) begin
         div_rem_ff <= (div_trial >= {1'b0, div_den_ff}) ? div_diff[HASH_W-1:0]
                                                         : div_trial[HASH_W-1:0];
         div_dvd_ff <= {div_dvd_ff[HASH_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.take_byte && is_last) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_data_ff <= div_rem_ff;
      end
   end

   assign status.div_last = (div_cnt_ff == '1);
   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

endmodule

// ===== hdl/psh_checker.sv =====
// Port-level checks for the polynomial string hash unit, bound to the top level.
module psh_checker import psh_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              req_tlast,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [HASH_W-1:0] rsp_tdata
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // the end of a string blocks intake while the remainder runs
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input accepted during remainder pass");

   // a new result only follows a cycle with intake blocked
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared without a finished string");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind polynomial_string_hash_unit psh_checker u_psh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the polynomial string hash unit.
`timescale 1ns / 1ps

module tb_top;
   import psh_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 300;
   localparam int OMIT_MAX      = 8;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_BYTES   = 115;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              is_last;
   } char_beat_type;

   typedef logic [CHAR_W-1:0] char_q_type[$];

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;   // [7:0] char_byte
   logic                  req_tlast = 1'b0; // is_last
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [HASH_W-1:0]     rsp_tdata;        // [31:0] bucket
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   polynomial_string_hash_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // Register shadow
   logic [15:0]       cfg_start_offset = 16'd0;
   logic [15:0]       cfg_hash_length  = 16'd0;
   logic [7:0]        cfg_base_char    = 8'd0;
   logic [HASH_W-1:0] cfg_multiplier   = MULTIPLIER_RESET;
   logic [HASH_W-1:0] cfg_table_size   = TABLE_SIZE_RESET;
   logic [63:0]       cfg_omitted_set  = 64'd0;
   logic [3:0]        cfg_omitted_cnt  = 4'd0;

   // Per-string hash state
   logic [HASH_W-1:0] run_hash    = '0;
   logic [15:0]       str_pos     = '0;
   logic [15:0]       budget_left = '0;
   logic              terminated  = 1'b0;

   char_beat_type     string_beats[$];
   logic [HASH_W-1:0] bucket_expected[$];

   int error_count     = 0;
   int strings_queued  = 0;
   int bytes_accepted  = 0;
   int buckets_checked = 0;
   int csr_writes      = 0;

   task automatic report_mismatch(input string what, input logic [HASH_W-1:0] got,
                                  input logic [HASH_W-1:0] want);
      $display("ERROR %0t: %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic bit char_omitted(input logic [7:0] ch);
      int n;
      n = (cfg_omitted_cnt > OMIT_MAX) ? OMIT_MAX : int'(cfg_omitted_cnt);
      for (int i = 0; i < n; i++)
         if (cfg_omitted_set[8*i +: 8] == ch) return 1'b1;
      return 1'b0;
   endfunction

   // Folds one byte into the running hash; returns 1 with the bucket on the last byte.
   function automatic bit fold_char(input logic [7:0] ch, input logic is_last,
                                    output logic [HASH_W-1:0] bucket);
      bucket = '0;
      if (str_pos == 16'd0) budget_left = cfg_hash_length;
      if (!terminated) begin
         if (ch == 8'd0) begin
            terminated = 1'b1;
         end else if (str_pos >= cfg_start_offset || str_pos == 16'hFFFF) begin
            if (budget_left != 16'd0 && !char_omitted(ch)) begin
               budget_left = budget_left - 16'd1;
               run_hash = (HASH_W'(ch) - HASH_W'(cfg_base_char)) + cfg_multiplier * run_hash;
            end
         end
      end
      if (str_pos != 16'hFFFF) str_pos = str_pos + 16'd1;
      if (is_last) begin
         bucket = (cfg_table_size == '0) ? run_hash : run_hash % cfg_table_size;
         run_hash   = '0;
         str_pos    = '0;
         terminated = 1'b0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Sender: bursts of random length separated by random gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin : drive_proc
      char_beat_type next_beat;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (string_beats.size() != 0) begin
            next_beat  = string_beats.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_beat.ch;
            req_tlast  <= next_beat.is_last;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 48);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: rotating stall patterns plus two long hold-offs
   int stall_left   = 0;
   int ready_mode   = 0;
   int mode_timer   = 0;
   int buckets_seen = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (mode_timer == 150) begin
            mode_timer <= 0;
            ready_mode <= $urandom_range(0, 3);
         end else begin
            mode_timer <= mode_timer + 1;
         end
         if (rsp_tvalid && rsp_tready) buckets_seen <= buckets_seen + 1;
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_tvalid && rsp_tready && (buckets_seen == 30 || buckets_seen == 80)) begin
            stall_left <= LONG_HOLD;
            rsp_tready <= 1'b0;
         end else begin
            case (ready_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ((mode_timer % 7) < 4);
            endcase
         end
      end
   end

   // Monitor: predict on accepted bytes, check accepted buckets
   always @(posedge clock) begin : monitor_proc
      logic [HASH_W-1:0] want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (bucket_expected.size() == 0) begin
               report_mismatch("bucket with no string pending", rsp_tdata, '0);
            end else begin
               want = bucket_expected.pop_front();
               buckets_checked++;
               if (rsp_tdata !== want) report_mismatch("bucket", rsp_tdata, want);
            end
         end
         if (req_tvalid && req_tready) begin
            bytes_accepted++;
            if (fold_char(req_tdata, req_tlast, want)) bucket_expected.push_back(want);
         end
      end
   end

   // Watchdog on cycles with no beat on any channel
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Timeout: no beat for %0d cycles", QUIET_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Must be called right after a rising edge; leaves csr_valid high.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_writes++;
      case (idx)
         CSR_START_OFFSET:  cfg_start_offset = val[15:0];
         CSR_HASH_LENGTH:   cfg_hash_length  = val[15:0];
         CSR_BASE_CHAR:     cfg_base_char    = val[7:0];
         CSR_MULTIPLIER:    cfg_multiplier   = val[31:0];
         CSR_TABLE_SIZE:    cfg_table_size   = val[31:0];
         CSR_OMITTED_SET:   cfg_omitted_set  = val;
         CSR_OMITTED_COUNT: cfg_omitted_cnt  = val[3:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [15:0] offset, input logic [15:0] length,
                                input logic [7:0] base, input logic [31:0] mult,
                                input logic [31:0] tsize, input logic [63:0] oset,
                                input logic [3:0] ocount);
      write_csr(CSR_START_OFFSET, 64'(offset));
      write_csr(CSR_HASH_LENGTH, 64'(length));
      write_csr(CSR_BASE_CHAR, 64'(base));
      write_csr(CSR_MULTIPLIER, 64'(mult));
      write_csr(CSR_TABLE_SIZE, 64'(tsize));
      write_csr(CSR_OMITTED_SET, oset);
      write_csr(CSR_OMITTED_COUNT, 64'(ocount));
      csr_valid <= 1'b0;
   endtask

   task automatic queue_chars(input char_q_type chars);
      foreach (chars[i]) string_beats.push_back('{ch: chars[i], is_last: i == chars.size() - 1});
      strings_queued++;
   endtask

   task automatic queue_random_string(input int unsigned len);
      char_q_type chars;
      int unsigned pick;
      for (int unsigned i = 0; i < len; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 3)       chars.push_back(8'd0);
         else if (pick < 30) chars.push_back(cfg_omitted_set[8*$urandom_range(0, 7) +: 8]);
         else                chars.push_back(8'($urandom_range(1, 255)));
      end
      queue_chars(chars);
   endtask

   // Returns at a rising edge once the block is idle and has settled.
   task automatic drain_and_settle();
      do @(posedge clock);
      while (string_beats.size() != 0 || req_tvalid || bucket_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 4))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'hFFFF_FFFF;
         3: return 32'($urandom_range(2, 1000));
         default: return $urandom;
      endcase
   endfunction

   initial begin : stimulus
      int phase_bytes;
      logic [15:0] offset, length;
      logic [7:0] base;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Power-on settings: empty budget, single bucket
      queue_chars('{8'h61, 8'h62});
      queue_chars('{8'h78});
      drain_and_settle();

      // Full budget, no modulo, vowels omitted
      load_settings(16'd0, 16'hFFFF, 8'd0, 32'd31, 32'd0, 64'h75_6F_69_65_61, 4'd5);
      queue_chars('{8'h68, 8'h65, 8'h6C, 8'h6C, 8'h6F});
      queue_chars('{8'hFF, 8'h01, 8'h80});
      queue_chars('{8'h41, 8'h00, 8'h42});
      queue_chars('{8'h00});
      drain_and_settle();

      // Offset, tight budget, bytes below base, oversized omit count
      load_settings(16'd3, 16'd2, 8'h61, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    64'hFFFF_FFFF_FFFF_FF20, 4'd15);
      queue_chars('{8'h62, 8'h63});
      queue_chars('{8'h62, 8'h00, 8'h63, 8'h64, 8'h65});
      queue_chars('{8'h01, 8'h02, 8'h03, 8'h20, 8'h05, 8'h60, 8'hFF, 8'h70});
      queue_chars('{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06});
      drain_and_settle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 5))
            0: offset = 16'd0;
            4: offset = 16'($urandom_range(7, 40));
            5: offset = 16'hFFFF;
            default: offset = 16'($urandom_range(1, 6));
         endcase
         case ($urandom_range(0, 5))
            0: length = 16'd0;
            4: length = 16'hFFFF;
            5: length = 16'($urandom_range(0, 65535));
            default: length = 16'($urandom_range(1, 10));
         endcase
         case ($urandom_range(0, 2))
            0: base = 8'd0;
            1: base = 8'hFF;
            default: base = 8'($urandom_range(0, 255));
         endcase
         load_settings(offset, length, base, pick_word(), pick_word(), {$urandom, $urandom},
                       4'($urandom_range(0, 15)));
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            int unsigned len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            queue_random_string(len);
            phase_bytes += len;
         end
         drain_and_settle();
      end

      if (bucket_expected.size() != 0)
         report_mismatch("buckets never delivered", HASH_W'(bucket_expected.size()), '0);
      $display("Run covered %0d strings, %0d bytes and %0d buckets over %0d register writes",
               strings_queued, bytes_accepted, buckets_checked, csr_writes);
      $display("Settings spanned offsets up to the maximum, empty and full budgets, zero table size");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/psh_pkg.sv
hdl/psh_ctrl.sv
hdl/psh_datapath.sv
hdl/polynomial_string_hash_unit.sv
hdl/psh_checker.sv
verif/tb_top.sv
